// ===== rtl/core/aesctr_pkg.sv =====
// shared types, s-box table and round helpers for the aes-128 ctr cipher
package aesctr_pkg;

    localparam int unsigned NumRounds  = 10;
    localparam int unsigned NumLanes   = 4;
    localparam int unsigned DataWidth  = 64;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned VbWidth    = 5;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_KEY_HIGH  = 2'd0,
        CFG_KEY_LOW   = 2'd1,
        CFG_NONCE     = 2'd2
    } cfg_idx_t;

    typedef logic [127:0] block_t;
    typedef logic [3:0]   round_t;

    // sideband that travels with a block through the round pipeline
    typedef struct packed {
        logic                 valid;
        logic [DataWidth-1:0] data_high;
        logic [DataWidth-1:0] data_low;
        logic [VbWidth-1:0]   valid_bytes;
        logic [DataWidth-1:0] counter;
    } side_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        begin
            case (a)
                8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
                8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
                8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
                8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
                8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
                8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
                8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
                8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
                8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
                8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
                8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
                8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
                8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
                8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
                8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
                8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
                8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
                8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
                8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
                8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
                8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
                8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
                8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
                8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
                8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
                8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
                8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
                8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
                8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
                8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
                8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
                8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
                8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
                8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
                8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
                8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
                8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
                8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
                8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
                8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
                8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
                8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
                8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
                8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
                8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
                8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
                8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
                8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
                8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
                8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
                8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
                8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
                8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
                8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
                8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
                8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
                8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
                8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
                8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
                8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
                8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
                8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
                8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
                8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input round_t rnd);
        logic [7:0] r;
        begin
            case (rnd)
                4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
                4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
                4'd9: r = 8'h1b; 4'd10: r = 8'h36;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    // byte i of a block sits at bits 127-8i .. 120-8i
    function automatic logic [7:0] byte_at(input block_t b, input int unsigned i);
        return b[127 - 8*i -: 8];
    endfunction

    // next round key from the previous one
    function automatic block_t next_key(input block_t k, input round_t rnd);
        logic [31:0] w0, w1, w2, w3, t;
        begin
            w0 = k[127:96];
            w1 = k[95:64];
            w2 = k[63:32];
            w3 = k[31:0];
            t = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]),
                 sbox(w3[31:24])};
            w0 = w0 ^ t;
            w1 = w1 ^ w0;
            w2 = w2 ^ w1;
            w3 = w3 ^ w2;
            return {w0, w1, w2, w3};
        end
    endfunction

endpackage

// ===== rtl/core/aesctr_lane.sv =====
// aes round lane: subbytes on a shifted column, mixcolumns unless last
module aesctr_lane (
    input  logic [31:0] column,
    input  logic        last,
    output logic [31:0] result
);

    logic [7:0] a0, a1, a2, a3, all;

    always_comb
    begin
        a0 = aesctr_pkg::sbox(column[31:24]);
        a1 = aesctr_pkg::sbox(column[23:16]);
        a2 = aesctr_pkg::sbox(column[15:8]);
        a3 = aesctr_pkg::sbox(column[7:0]);
        all = a0 ^ a1 ^ a2 ^ a3;
        if (last)
        begin
            result = {a0, a1, a2, a3};
        end
        else
        begin
            result = {a0 ^ all ^ aesctr_pkg::xtime(a0 ^ a1),
                      a1 ^ all ^ aesctr_pkg::xtime(a1 ^ a2),
                      a2 ^ all ^ aesctr_pkg::xtime(a2 ^ a3),
                      a3 ^ all ^ aesctr_pkg::xtime(a3 ^ a0)};
        end
    end

endmodule

// ===== rtl/core/aesctr_round.sv =====
// one pipelined aes round: four column lanes, key add and key schedule step
module aesctr_round (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  aesctr_pkg::round_t     rnd,
    input  aesctr_pkg::block_t     state_in,
    input  aesctr_pkg::block_t     key_in,
    input  aesctr_pkg::side_t      side_in,
    output aesctr_pkg::block_t     state_out,
    output aesctr_pkg::block_t     key_out,
    output aesctr_pkg::side_t      side_out
);

    aesctr_pkg::block_t state_reg, key_reg, key_next, mixed;
    aesctr_pkg::side_t  side_reg;
    logic               last;

    assign last     = (rnd == aesctr_pkg::round_t'(aesctr_pkg::NumRounds));
    assign key_next = aesctr_pkg::next_key(key_in, rnd);

    for (genvar c = 0; c < aesctr_pkg::NumLanes; c++)
    begin : g_lane
        logic [31:0] col;
        // shiftrows picks byte r from column c+r
        for (genvar r = 0; r < 4; r++)
        begin : g_row
            assign col[31 - 8*r -: 8] =
                aesctr_pkg::byte_at(state_in, 4 * ((c + r) % 4) + r);
        end
        aesctr_lane u_lane (
            .column (col),
            .last   (last),
            .result (mixed[127 - 32*c -: 32])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            key_reg   <= '0;
            side_reg  <= '0;
        end
        else if (advance)
        begin
            state_reg <= mixed ^ key_next;
            key_reg   <= key_next;
            side_reg  <= side_in;
        end
    end

    assign state_out = state_reg;
    assign key_out   = key_reg;
    assign side_out  = side_reg;

endmodule

// ===== rtl/core/aes128_ctr_stream_cipher.sv =====
// top level of the aes-128 counter-mode stream cipher
// Usage:
//   input channel in_valid/in_ready carries func, block_high, block_low and
//   valid_bytes; one beat is one 16-byte block, byte 0 in the top bits.
//   output channel out_valid/out_ready carries out_high, out_low and the
//   block counter used (counter_used). one result beat per input beat.
//   cfg_we/cfg_index/cfg_data write key_high (0), key_low (1), nonce (2);
//   write only while no block is in flight.
// Pipeline: input register, ten round stages, output merge register between
//   input beat and output beat; all of them hold while stalled.
// Throughput: one block per cycle while not stalled; the ten unrolled round
//   stages, each with its own key schedule step, take a new block while advancing.
// Stalls: the whole pipeline holds while the output register is full and
//   out_ready is low; in_ready is low only then.
// Reset: counter goes to zero, all stages empty, config registers zero.
module aes128_ctr_stream_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic [4:0]  valid_bytes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_high,
    output logic [63:0] out_low,
    output logic [63:0] counter_used,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int unsigned NR = aesctr_pkg::NumRounds;

    logic [63:0] key_high_reg, key_low_reg, nonce_reg, counter_reg;
    logic [63:0] ctr_cur;
    logic        advance, accept;

    aesctr_pkg::block_t state_pipe [NR+1];
    aesctr_pkg::block_t key_pipe   [NR+1];
    aesctr_pkg::side_t  side_pipe  [NR+1];

    aesctr_pkg::block_t ks, data, merged;
    aesctr_pkg::side_t  last_side;

    logic        out_valid_reg;
    logic [63:0] out_high_reg, out_low_reg, counter_used_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;
    assign ctr_cur  = func ? 64'd0 : counter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            nonce_reg    <= '0;
            counter_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    aesctr_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    aesctr_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    aesctr_pkg::CFG_NONCE:    nonce_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                counter_reg <= ctr_cur + 64'd1;
            end
        end
    end

    // input stage: initial key add on the counter block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_pipe[0] <= '0;
            key_pipe[0]   <= '0;
            side_pipe[0]  <= '0;
        end
        else if (advance)
        begin
            state_pipe[0] <= {nonce_reg,
                              ctr_cur[7:0], ctr_cur[15:8], ctr_cur[23:16], ctr_cur[31:24],
                              ctr_cur[39:32], ctr_cur[47:40], ctr_cur[55:48], ctr_cur[63:56]}
                             ^ {key_high_reg, key_low_reg};
            key_pipe[0]              <= {key_high_reg, key_low_reg};
            side_pipe[0].valid       <= accept;
            side_pipe[0].data_high   <= block_high;
            side_pipe[0].data_low    <= block_low;
            side_pipe[0].valid_bytes <= valid_bytes;
            side_pipe[0].counter     <= ctr_cur;
        end
    end

    for (genvar i = 0; i < NR; i++)
    begin : g_round
        aesctr_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .rnd       (aesctr_pkg::round_t'(i + 1)),
            .state_in  (state_pipe[i]),
            .key_in    (key_pipe[i]),
            .side_in   (side_pipe[i]),
            .state_out (state_pipe[i+1]),
            .key_out   (key_pipe[i+1]),
            .side_out  (side_pipe[i+1])
        );
    end

    assign ks        = state_pipe[NR];
    assign last_side = side_pipe[NR];
    assign data      = {last_side.data_high, last_side.data_low};

    // merge: xor keystream and zero the bytes past valid_bytes
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            if (5'(i) < last_side.valid_bytes)
            begin
                merged[127 - 8*i -: 8] = data[127 - 8*i -: 8] ^ ks[127 - 8*i -: 8];
            end
            else
            begin
                merged[127 - 8*i -: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= last_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_high_reg     <= merged[127:64];
            out_low_reg      <= merged[63:0];
            counter_used_reg <= last_side.counter;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_high     = out_high_reg;
    assign out_low      = out_low_reg;
    assign counter_used = counter_used_reg;

    // a new message always restarts the counter at one
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func) |=> (counter_reg == 64'd1))
        else $error("counter not restarted on new message");

    // a continued block moves the counter by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !func) |=> (counter_reg == $past(counter_reg) + 64'd1))
        else $error("counter step wrong");

    // the counter only moves on an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(counter_reg))
        else $error("counter moved without a beat");

    // a stalled output stays valid and holds its counter_used
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(counter_used)))
        else $error("stalled result changed");

endmodule
